// File: rtl/wrv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrv_pkg
// Shared widths, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package wrv_pkg;

  localparam int CW     = 38;  // CORDIC x/y datapath width
  localparam int ZW     = 22;  // angle width, signed Q6.16
  localparam int STEPS  = 17;  // CORDIC iterations
  localparam int IW     = 5;   // iteration counter width
  localparam int MW     = 35;  // multiplier operand width

  localparam logic signed [ZW-1:0] PI_Q      = 22'sd205887;
  localparam logic signed [ZW-1:0] HALF_PI_Q = 22'sd102944;
  localparam logic signed [ZW-1:0] TWO_PI_Q  = 22'sd411775;
  localparam logic signed [CW-1:0] CORDIC_K  = 38'sd652032874;

  // round(atan(2^-i) * 65536)
  function automatic logic signed [ZW-1:0] atan_tab(input logic [IW-1:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0:    r = 22'sd51472;
      5'd1:    r = 22'sd30386;
      5'd2:    r = 22'sd16055;
      5'd3:    r = 22'sd8150;
      5'd4:    r = 22'sd4091;
      5'd5:    r = 22'sd2047;
      5'd6:    r = 22'sd1024;
      5'd7:    r = 22'sd512;
      5'd8:    r = 22'sd256;
      5'd9:    r = 22'sd128;
      5'd10:   r = 22'sd64;
      5'd11:   r = 22'sd32;
      5'd12:   r = 22'sd16;
      5'd13:   r = 22'sd8;
      5'd14:   r = 22'sd4;
      5'd15:   r = 22'sd2;
      5'd16:   r = 22'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/wrv_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrv_cordic
// Iterative CORDIC, one shift-add step per cycle, vectoring or rotation mode.
// ----------------------------------------------------------------------------
module wrv_cordic (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            vec_mode_i,
  input  logic signed [wrv_pkg::CW-1:0]   x0_i,
  input  logic signed [wrv_pkg::CW-1:0]   y0_i,
  input  logic signed [wrv_pkg::ZW-1:0]   z0_i,
  output logic signed [wrv_pkg::CW-1:0]   x_o,
  output logic signed [wrv_pkg::CW-1:0]   y_o,
  output logic signed [wrv_pkg::ZW-1:0]   z_o,
  output logic                            done_o
);

  logic signed [wrv_pkg::CW-1:0] x_q, y_q, x_d, y_d, xs, ys;
  logic signed [wrv_pkg::ZW-1:0] z_q, z_d, t;
  logic [wrv_pkg::IW-1:0]        i_q;
  logic                          busy_q, done_q, vec_q, pos;

  // one micro-rotation
  always_comb begin
    xs  = x_q >>> i_q;
    ys  = y_q >>> i_q;
    t   = wrv_pkg::atan_tab(i_q);
    pos = vec_q ? (y_q >= 0) : (z_q >= 0);
    if (vec_q == pos) begin
      // vectoring with y >= 0, or rotation with z < 0
      x_d = x_q + ys;
      y_d = y_q - xs;
    end else begin
      x_d = x_q - ys;
      y_d = y_q + xs;
    end
    z_d = pos ? ((vec_q) ? z_q + t : z_q - t) : ((vec_q) ? z_q - t : z_q + t);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      i_q    <= '0;
    end else if (busy_q) begin
      i_q <= i_q + 1'b1;
      if (i_q == wrv_pkg::IW'(wrv_pkg::STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x0_i;
      y_q   <= y0_i;
      z_q   <= z0_i;
      vec_q <= vec_mode_i;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign done_o = done_q;

endmodule

// File: rtl/wrv_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrv_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module wrv_mul (
  input  logic                              clk_i,
  input  logic signed [wrv_pkg::MW-1:0]     a_i,
  input  logic signed [wrv_pkg::MW-1:0]     b_i,
  output logic signed [2*wrv_pkg::MW-1:0]   p_o
);

  logic signed [2*wrv_pkg::MW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// File: rtl/waypoint_reference_velocity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_reference_velocity
// Turns path waypoints into heading, body-frame velocity and turn rate.
// ----------------------------------------------------------------------------
// Waypoints arrive on the s_axis channel (tuser = first of path, tlast = last
// of path); one reference state per waypoint leaves on m_axis. Registers are
// written through the cfg channel, which is always ready; the user must
// write them only while the block is idle, which the block does not enforce.
// From its s_axis transfer to m_axis_tvalid, one waypoint passes through these
// steps in order: the quaternion terms and position differences, a 17-step
// vectoring CORDIC on the yaw, a 17-step rotation CORDIC on cos/sin (both on
// one iterative shift-add unit), seven products through one shared
// multiplier, and the limit check. A new waypoint is taken only once the last
// one is through; s_axis_tready is high only in the idle state.
// The result sits in an output register; a stalled receiver holds the block
// after its next item finishes until the register is taken.
// Reset clears the prior point, the held path-end state and sets the
// registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module waypoint_reference_velocity (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // pos_x, pos_y, quat_x, quat_y, quat_z, quat_w
  input  logic [127:0]  s_axis_tdata,
  // first_of_path
  input  logic          s_axis_tuser,
  // last_of_path
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // ref_x, ref_y, ref_heading, ref_surge, ref_sway, ref_turn_rate, 3 zero bits
  output logic [183:0]  m_axis_tdata,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [7:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  localparam int CW = wrv_pkg::CW;
  localparam int ZW = wrv_pkg::ZW;
  localparam int MW = wrv_pkg::MW;

  localparam logic [7:0] REG_INV_STEP = 8'd0;
  localparam logic [7:0] REG_LIN_LIM  = 8'd1;
  localparam logic [7:0] REG_TURN_LIM = 8'd2;

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_ATAN, S_ROT, S_MUL, S_FIN} state_e;

  // configuration
  logic [22:0] inv_step_q;
  logic [30:0] lin_lim_q, turn_lim_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_step_q <= 23'd655360;
      lin_lim_q  <= 31'd65536;
      turn_lim_q <= 31'd34315;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_INV_STEP: inv_step_q <= cfg_data_i[22:0];
        REG_LIN_LIM:  lin_lim_q  <= cfg_data_i[30:0];
        REG_TURN_LIM: turn_lim_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // state
  state_e state_q;
  logic [2:0] m_q;
  logic signed [31:0] px_q, py_q, prior_x_q, prior_y_q;
  logic signed [ZW-1:0] prior_h_q;
  logic signed [31:0] held_x_q, held_y_q, held_s_q, held_w_q, held_t_q;
  logic signed [ZW-1:0] held_h_q;
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
  logic first_q, last_q, zero_q, fneg_q;
  logic signed [32:0] dx_q, dy_q;
  logic signed [ZW-1:0] dth_q, head_q;
  logic signed [33:0] c_q, s_q;
  logic signed [34:0] bx_q, by_q;
  logic signed [41:0] surge_q, sway_q, turn_q;
  logic m_valid_q;
  logic [183:0] m_data_q;
  logic out_load;

  // quaternion terms and pre-rotation
  logic signed [31:0] p_wz, p_xy, p_yy, p_zz;
  logic signed [33:0] num, den;
  logic signed [CW-1:0] vx0, vy0;
  logic signed [ZW-1:0] vz0;
  always_comb begin
    p_wz = 32'(qw_q) * 32'(qz_q);
    p_xy = 32'(qx_q) * 32'(qy_q);
    p_yy = 32'(qy_q) * 32'(qy_q);
    p_zz = 32'(qz_q) * 32'(qz_q);
    num = (34'(p_wz) + 34'(p_xy)) <<< 1;
    den = 34'sd1073741824 - ((34'(p_yy) + 34'(p_zz)) <<< 1);
    if (den < 0) begin
      if (num >= 0) begin
        vx0 = CW'(num);
        vy0 = -CW'(den);
        vz0 = wrv_pkg::HALF_PI_Q;
      end else begin
        vx0 = -CW'(num);
        vy0 = CW'(den);
        vz0 = -wrv_pkg::HALF_PI_Q;
      end
    end else begin
      vx0 = CW'(den);
      vy0 = CW'(num);
      vz0 = '0;
    end
  end

  // cordic unit
  logic cor_start, cor_vec, cor_done;
  logic signed [CW-1:0] cx0, cy0, cx, cy;
  logic signed [ZW-1:0] cz0, cz;

  wrv_cordic u_cordic (
    .clk_i, .rst_ni,
    .start_i(cor_start), .vec_mode_i(cor_vec),
    .x0_i(cx0), .y0_i(cy0), .z0_i(cz0),
    .x_o(cx), .y_o(cy), .z_o(cz), .done_o(cor_done)
  );

  // yaw, heading wrap and fold for rotation
  logic signed [ZW-1:0] yaw, bh, dth, head, fold;
  logic fneg;
  always_comb begin
    if (zero_q) yaw = '0;
    else if (cz > wrv_pkg::PI_Q) yaw = wrv_pkg::PI_Q;
    else if (cz < -wrv_pkg::PI_Q) yaw = -wrv_pkg::PI_Q;
    else yaw = cz;
    bh   = first_q ? held_h_q : prior_h_q;
    dth  = yaw - bh;
    head = yaw;
    if (dth > wrv_pkg::PI_Q) head = yaw - wrv_pkg::TWO_PI_Q;
    else if (dth < -wrv_pkg::PI_Q) head = yaw + wrv_pkg::TWO_PI_Q;
    fneg = 1'b0;
    fold = yaw;
    if (yaw > wrv_pkg::HALF_PI_Q) begin
      fold = yaw - wrv_pkg::PI_Q; fneg = 1'b1;
    end else if (yaw < -wrv_pkg::HALF_PI_Q) begin
      fold = yaw + wrv_pkg::PI_Q; fneg = 1'b1;
    end
  end

  always_comb begin
    cor_start = 1'b0;
    cor_vec   = 1'b1;
    cx0 = vx0; cy0 = vy0; cz0 = vz0;
    if (state_q == S_PREP) begin
      cor_start = 1'b1;
    end else if (state_q == S_ATAN && cor_done) begin
      cor_start = 1'b1;
      cor_vec   = 1'b0;
      cx0 = wrv_pkg::CORDIC_K; cy0 = '0; cz0 = fold;
    end
  end

  // shared multiplier operand select
  logic signed [MW-1:0] ma, mb;
  logic signed [2*MW-1:0] prod;
  logic signed [MW-1:0] step_s;
  logic signed [39:0] p30;
  assign step_s = MW'($signed({1'b0, inv_step_q}));
  assign p30    = 40'(prod >>> 30);

  always_comb begin
    unique case (m_q)
      3'd0: begin ma = MW'(c_q);  mb = MW'(dx_q); end
      3'd1: begin ma = MW'(s_q);  mb = MW'(dy_q); end
      3'd2: begin ma = MW'(c_q);  mb = MW'(dy_q); end
      3'd3: begin ma = MW'(s_q);  mb = MW'(dx_q); end
      3'd4: begin ma = MW'(dth_q); mb = step_s; end
      3'd5: begin ma = bx_q;      mb = step_s; end
      default: begin ma = by_q;   mb = step_s; end
    endcase
  end

  wrv_mul u_mul (.clk_i, .a_i(ma), .b_i(mb), .p_o(prod));

  // limit or hold
  logic signed [31:0] surge_o, sway_o, turn_o;
  logic signed [41:0] llim, tlim;
  always_comb begin
    llim = 42'($signed({1'b0, lin_lim_q}));
    tlim = 42'($signed({1'b0, turn_lim_q}));
    surge_o = (surge_q > llim || surge_q < -llim) ? held_s_q : surge_q[31:0];
    sway_o  = (sway_q  > llim || sway_q  < -llim) ? held_w_q : sway_q[31:0];
    turn_o  = (turn_q  > tlim || turn_q  < -tlim) ? held_t_q : turn_q[31:0];
  end

  // output register loads when it is empty or being taken
  assign out_load = (state_q == S_FIN) && (!m_valid_q || m_axis_tready);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_q       <= '0;
      m_valid_q <= 1'b0;
      prior_x_q <= '0; prior_y_q <= '0; prior_h_q <= '0;
      held_x_q  <= '0; held_y_q  <= '0; held_h_q  <= '0;
      held_s_q  <= '0; held_w_q  <= '0; held_t_q  <= '0;
    end else begin
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            px_q <= s_axis_tdata[31:0];
            py_q <= s_axis_tdata[63:32];
            qx_q <= s_axis_tdata[79:64];
            qy_q <= s_axis_tdata[95:80];
            qz_q <= s_axis_tdata[111:96];
            qw_q <= s_axis_tdata[127:112];
            first_q <= s_axis_tuser;
            last_q  <= s_axis_tlast;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          zero_q <= (num == 0) && (den == 0);
          dx_q <= 33'(px_q) - 33'(first_q ? held_x_q : prior_x_q);
          dy_q <= 33'(py_q) - 33'(first_q ? held_y_q : prior_y_q);
          state_q <= S_ATAN;
        end
        S_ATAN: begin
          if (cor_done) begin
            dth_q   <= dth;
            head_q  <= head;
            fneg_q  <= fneg;
            state_q <= S_ROT;
          end
        end
        S_ROT: begin
          if (cor_done) begin
            c_q <= fneg_q ? -34'(cx) : 34'(cx);
            s_q <= fneg_q ? -34'(cy) : 34'(cy);
            m_q <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          m_q <= m_q + 1'b1;
          unique case (m_q)
            3'd1: bx_q <= 35'(p30);
            3'd2: bx_q <= 35'(bx_q + 35'(p30));
            3'd3: by_q <= 35'(p30);
            3'd4: by_q <= 35'(by_q - 35'(p30));
            3'd5: turn_q  <= 42'(prod >>> 16);
            3'd6: surge_q <= 42'(prod >>> 16);
            3'd7: begin
              sway_q  <= 42'(prod >>> 16);
              state_q <= S_FIN;
            end
            default: ;
          endcase
        end
        S_FIN: begin
          if (out_load) begin
            m_data_q  <= {3'b000, turn_o, sway_o, surge_o, head_q[20:0], py_q, px_q};
            prior_x_q <= px_q;
            prior_y_q <= py_q;
            prior_h_q <= head_q;
            if (last_q) begin
              held_x_q <= px_q; held_y_q <= py_q; held_h_q <= head_q;
              held_s_q <= surge_o; held_w_q <= sway_o; held_t_q <= turn_o;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for waypoint_reference_velocity.
// ----------------------------------------------------------------------------
// A directed table of waypoints runs first: zero vector, field extremes,
// an upward heading wrap and first/last combinations. Random paths
// and noise items follow, in phases with different register settings and
// different sender idle and receiver stall patterns. Every reference state,
// but for the zero-vector table rows, is predicted by a fixed-point model kept
// in this file and compared field by field with the m_axis transfer.
// ----------------------------------------------------------------------------
module testbench;

  localparam longint PI_Q      = 205887;
  localparam longint HALF_PI_Q = 102944;
  localparam longint TWO_PI_Q  = 411775;
  localparam longint K_Q30     = 652032874;
  localparam longint ONE_Q30   = 1073741824;
  localparam int     N_ROT     = 17;
  localparam int     RAND_ITEMS = 500;   // per phase
  localparam int     DRAIN_CYCLES = 100;

  localparam longint ATAN_Q[N_ROT] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
                                       512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

  typedef enum logic [7:0] {
    REG_INV_STEP  = 8'd0,
    REG_LIN_LIMIT = 8'd1,
    REG_TURN_LIMIT = 8'd2,
    REG_SPARE     = 8'd3
  } reg_idx_e;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} idle_phase_e;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    bit                 first;
    bit                 last;
  } waypoint_t;

  typedef struct {
    waypoint_t    wp;
    bit           typed;
    logic [183:0] ref_state;
  } wp_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [127:0]  s_axis_tdata = '0;
  logic          s_axis_tuser = 1'b0;
  logic          s_axis_tlast = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [183:0]  m_axis_tdata;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [7:0]    cfg_index_i = '0;
  logic [31:0]   cfg_data_i = '0;

  waypoint_reference_velocity u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Generous cap on the whole run
  initial begin
    #30ms;
    $display("testbench: errors");
    $finish;
  end

  // Tracker state and register copies
  longint prev_x, prev_y, prev_head;
  longint path_end[6];
  longint inv_step, lin_limit, turn_limit;
  logic [183:0] ref_q[$];
  int errors = 0;
  idle_phase_e phase = PH_FREE;
  bit hold_go = 1'b0;

  function automatic longint heading_of(longint y, longint x);
    longint z, t, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_Q;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_Q;
      end
    end
    for (int i = 0; i < N_ROT; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_Q[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_Q[i];
      end
      x = nx; y = ny;
    end
    if (z > PI_Q) z = PI_Q;
    if (z < -PI_Q) z = -PI_Q;
    return z;
  endfunction

  function automatic void rotate_unit(input longint a, output longint c, output longint s);
    longint x, y, nx, ny;
    bit flip;
    x = K_Q30; y = 0; flip = 0;
    if (a > HALF_PI_Q) begin
      a -= PI_Q; flip = 1;
    end else if (a < -HALF_PI_Q) begin
      a += PI_Q; flip = 1;
    end
    for (int i = 0; i < N_ROT; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); a -= ATAN_Q[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); a += ATAN_Q[i];
      end
      x = nx; y = ny;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint clip_or_hold(longint v, longint lim, longint held);
    return (v > lim || v < -lim) ? held : v;
  endfunction

  // Reference state for one waypoint; advances the tracker state
  function automatic logic [183:0] next_ref_state(waypoint_t w);
    longint px, py, qx, qy, qz, qw, num, den, yaw, bx, by, bh;
    longint dx, dy, dth, head, c, s, bxv, byv, sg, sw, tr;
    px = w.pos_x; py = w.pos_y;
    qx = w.qx; qy = w.qy; qz = w.qz; qw = w.qw;
    num = 2 * (qw * qz + qx * qy);
    den = ONE_Q30 - 2 * (qy * qy + qz * qz);
    yaw = heading_of(num, den);
    if (w.first) begin
      bx = path_end[0]; by = path_end[1]; bh = path_end[2];
    end else begin
      bx = prev_x; by = prev_y; bh = prev_head;
    end
    dx = px - bx; dy = py - by; dth = yaw - bh;
    head = yaw;
    if (dth > PI_Q) head -= TWO_PI_Q;
    else if (dth < -PI_Q) head += TWO_PI_Q;
    rotate_unit(yaw, c, s);
    bxv = ((c * dx) >>> 30) + ((s * dy) >>> 30);
    byv = ((c * dy) >>> 30) - ((s * dx) >>> 30);
    sg = clip_or_hold((bxv * inv_step) >>> 16, lin_limit, path_end[3]);
    sw = clip_or_hold((byv * inv_step) >>> 16, lin_limit, path_end[4]);
    tr = clip_or_hold((dth * inv_step) >>> 16, turn_limit, path_end[5]);
    prev_x = px; prev_y = py; prev_head = head;
    if (w.last) begin
      path_end[0] = px; path_end[1] = py; path_end[2] = head;
      path_end[3] = sg; path_end[4] = sw; path_end[5] = tr;
    end
    return {3'b000, tr[31:0], sw[31:0], sg[31:0], head[20:0], py[31:0], px[31:0]};
  endfunction

  // Receiver: stall pattern per phase, plus one long hold-off
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (phase == PH_RECV_STALL) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 60);
    end else if (phase == PH_BOTH) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 24);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic void cmp_field(string nm, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, nm, e, a);
      errors++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    logic [183:0] e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (ref_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = ref_q.pop_front();
        cmp_field("ref_x", e[31:0], m_axis_tdata[31:0]);
        cmp_field("ref_y", e[63:32], m_axis_tdata[63:32]);
        cmp_field("ref_heading", {11'b0, e[84:64]}, {11'b0, m_axis_tdata[84:64]});
        cmp_field("ref_surge", e[116:85], m_axis_tdata[116:85]);
        cmp_field("ref_sway", e[148:117], m_axis_tdata[148:117]);
        cmp_field("ref_turn_rate", e[180:149], m_axis_tdata[180:149]);
        cmp_field("pad", {29'b0, e[183:181]}, {29'b0, m_axis_tdata[183:181]});
      end
    end
  end

  // Offer one waypoint and wait for its transfer; leaves tvalid high
  task automatic send_waypoint(waypoint_t w, bit typed, logic [183:0] typed_ref);
    logic [183:0] p;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w.qw, w.qz, w.qy, w.qx, w.pos_y, w.pos_x};
    s_axis_tuser  <= w.first;
    s_axis_tlast  <= w.last;
    do @(posedge clk_i); while (!s_axis_tready);
    p = next_ref_state(w);
    ref_q.insert(ref_q.size(), typed ? typed_ref : p);
  endtask

  task automatic sender_gap();
    int pct;
    pct = (phase == PH_SEND_IDLE) ? 60 : (phase == PH_BOTH) ? 24 : 0;
    if ($urandom_range(0, 99) < pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (ref_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_INV_STEP:   inv_step   = val & 32'h007F_FFFF;
      REG_LIN_LIMIT:  lin_limit  = val & 32'h7FFF_FFFF;
      REG_TURN_LIMIT: turn_limit = val & 32'h7FFF_FFFF;
      default: ;
    endcase
  endtask

  function automatic waypoint_t noise_wp();
    waypoint_t w;
    w.pos_x = $urandom; w.pos_y = $urandom;
    w.qx = $urandom; w.qy = $urandom; w.qz = $urandom; w.qw = $urandom;
    w.first = $urandom; w.last = $urandom;
    return w;
  endfunction

  // Random part: mostly well-formed paths with small steps, some noise
  task automatic run_random(int n);
    waypoint_t w;
    int sent, len;
    logic signed [31:0] cx, cy;
    sent = 0;
    cx = $urandom_range(0, 65535) - 32768;
    cy = $urandom_range(0, 65535) - 32768;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          cx += $signed($urandom_range(0, 32767)) - 16384;
          cy += $signed($urandom_range(0, 32767)) - 16384;
          w.pos_x = cx; w.pos_y = cy;
          if ($urandom_range(0, 3) == 0) begin
            w.qx = $urandom; w.qy = $urandom;
          end else begin
            w.qx = 0; w.qy = 0;
          end
          w.qz = $urandom; w.qw = $urandom;
          w.first = (k == 0); w.last = (k == len - 1);
          send_waypoint(w, 1'b0, '0);
          sender_gap();
          sent++;
        end
      end else begin
        send_waypoint(noise_wp(), 1'b0, '0);
        sender_gap();
        sent++;
      end
    end
  endtask

  function automatic waypoint_t mk(logic signed [31:0] x, logic signed [31:0] y,
                                   logic signed [15:0] a, logic signed [15:0] b,
                                   logic signed [15:0] c, logic signed [15:0] d,
                                   bit f, bit l);
    waypoint_t w;
    w.pos_x = x; w.pos_y = y; w.qx = a; w.qy = b; w.qz = c; w.qw = d;
    w.first = f; w.last = l;
    return w;
  endfunction

  wp_row_t rows[$];

  initial begin
    inv_step = 655360; lin_limit = 65536; turn_limit = 34315;
    prev_x = 0; prev_y = 0; prev_head = 0;
    foreach (path_end[k]) path_end[k] = 0;

    // Directed table: zero-vector rows read off directly, others predicted
    rows.insert(rows.size(), '{mk(0, 0, 0, 16384, 16384, 0, 0, 0), 1, '0});
    rows.insert(rows.size(), '{mk(0, 0, 0, 16384, 16384, 0, 1, 1), 1, '0});
    rows.insert(rows.size(),
                '{mk(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 32767, 0, 0), 0, '0});
    rows.insert(rows.size(),
                '{mk(32'sh8000_0000, 32'sh7FFF_FFFF, -32768, -32768, -32768, -32768,
                     1, 0), 0, '0});
    rows.insert(rows.size(), '{mk(1000, 2000, 32767, 32767, 32767, 32767, 0, 0), 0, '0});
    // heading near +pi, then near -pi: wraps upward
    rows.insert(rows.size(), '{mk(3000, 2000, 0, 0, 32767, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), '{mk(4000, 2000, 0, 0, 32767, -1, 0, 0), 0, '0});
    // and back near +pi: no wrap, the prior heading being already near +pi
    rows.insert(rows.size(), '{mk(5000, 2000, 0, 0, 32767, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), '{mk(6000, 2500, 0, 0, 23170, 23170, 0, 1), 0, '0});
    rows.insert(rows.size(), '{mk(6100, 2600, 0, 0, 23170, 23170, 1, 0), 0, '0});
    rows.insert(rows.size(), '{mk(6200, 2700, 0, 0, -23170, 23170, 0, 1), 0, '0});
    rows.insert(rows.size(), '{mk(70000, -70000, 0, 0, 0, -32768, 1, 1), 0, '0});
    rows.insert(rows.size(), '{mk(-1, -1, 0, 0, -32768, 0, 0, 0), 0, '0});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) begin
      send_waypoint(rows[r].wp, rows[r].typed, rows[r].ref_state);
      sender_gap();
    end

    // Phase 1: default registers, no idling, one long receiver hold-off
    phase = PH_FREE;
    hold_go <= 1'b1;
    run_random(RAND_ITEMS);

    // Phase 2: extremes, all-ones data masked by the register widths
    wait_idle();
    write_reg(REG_INV_STEP, 32'd6553600);
    write_reg(REG_LIN_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_TURN_LIMIT, 32'h7FFF_FFFF);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    phase = PH_SEND_IDLE;
    run_random(RAND_ITEMS);

    // Phase 3: zero limits, first with a zero step and then with a step of 65
    wait_idle();
    write_reg(REG_INV_STEP, 32'd0);
    write_reg(REG_LIN_LIMIT, 32'd0);
    write_reg(REG_TURN_LIMIT, 32'd0);
    phase = PH_RECV_STALL;
    run_random(RAND_ITEMS / 2);
    wait_idle();
    write_reg(REG_INV_STEP, 32'd65);
    write_reg(REG_LIN_LIMIT, 32'd0);
    run_random(RAND_ITEMS / 2);

    // Phase 4: random settings
    wait_idle();
    write_reg(REG_INV_STEP, $urandom_range(65, 6553600));
    write_reg(REG_LIN_LIMIT, $urandom_range(0, 32'h0004_0000));
    write_reg(REG_TURN_LIMIT, $urandom_range(0, 32'h0002_0000));
    phase = PH_BOTH;
    run_random(RAND_ITEMS);

    wait_idle();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
